@@ hdl/crfs_pkg.sv @@
package crfs_pkg;

    // Field and datapath widths
    localparam int IDX_W = 20;
    localparam int DIM_W = 11;
    localparam int KER_W = 4;
    localparam int STR_W = 4;
    localparam int PAD_W = 4;

    // Defaults for the top-level saturation bounds
    localparam int MAX_DIM_DEF    = 1024;
    localparam int MAX_KERNEL_DEF = 15;

    // Result of an empty range, and the top of the index range
    localparam logic [IDX_W-1:0] EMPTY_MIN = 20'd1000000;
    localparam logic [IDX_W-1:0] IDX_MAX   = 20'hFFFFF;

    // Job queue between front and back
    localparam int QDEPTH = 2;

    // APB register file
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int RIDX_W = ADDR_W - 2;

    localparam logic [RIDX_W-1:0] REG_INPUT_HEIGHT  = 3'd0;
    localparam logic [RIDX_W-1:0] REG_INPUT_WIDTH   = 3'd1;
    localparam logic [RIDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [RIDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [RIDX_W-1:0] REG_STRIDES       = 3'd4;
    localparam logic [RIDX_W-1:0] REG_PAD_TOP       = 3'd5;
    localparam logic [RIDX_W-1:0] REG_PAD_LEFT      = 3'd6;
    localparam logic [RIDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd7;

    // Input request: inclusive range of flat output indices
    typedef struct packed {
        logic [IDX_W-1:0] first_output_index;
        logic [IDX_W-1:0] last_output_index;
    } t_in_req;

    // Result: span of the input window over the range
    typedef struct packed {
        logic [IDX_W-1:0] min_input_index;
        logic [IDX_W-1:0] max_input_index;
    } t_out_rsp;

    // Saturated configuration as seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0] input_height;
        logic [DIM_W-1:0] input_width;
        logic [KER_W-1:0] kernel_height;
        logic [KER_W-1:0] kernel_width;
        logic [STR_W-1:0] stride_v;
        logic [STR_W-1:0] stride_col;
        logic [PAD_W-1:0] pad_top;
        logic [PAD_W-1:0] pad_left;
        logic [DIM_W-1:0] output_width;
    } t_cfg;

    // Job handed from front to back: start position and walk length minus one
    typedef struct packed {
        logic             empty;
        logic [IDX_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [IDX_W-1:0] count;
    } t_job;

endpackage

@@ hdl/crfs_front.sv @@
module crfs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crfs_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    input  crfs_pkg::t_in_req  i_in_req,
    output logic               o_in_ready,
    output logic               o_push,
    output crfs_pkg::t_job     o_job,
    input  logic               i_full
);

    localparam int STEP_W = $clog2(crfs_pkg::IDX_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(crfs_pkg::IDX_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [STEP_W-1:0]             r_step, n_step;
    logic [crfs_pkg::IDX_W-1:0]    r_quo, n_quo;
    logic [crfs_pkg::DIM_W-1:0]    r_rem, n_rem;
    logic [crfs_pkg::IDX_W-1:0]    r_count, n_count;
    logic                          r_empty, n_empty;

    logic [crfs_pkg::DIM_W:0]      div_t;
    logic [crfs_pkg::DIM_W:0]      div_r;
    logic                          div_ge;

    // One restoring divide step: first index / output width
    always_comb begin
        div_t  = {r_rem, r_quo[crfs_pkg::IDX_W-1]};
        div_ge = div_t >= {1'b0, i_cfg.output_width};
        div_r  = div_ge ? (div_t - {1'b0, i_cfg.output_width}) : div_t;
    end

    // Sequencer: accept, divide (skipped for an empty range), hand the job to the queue
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_count = r_count;
        n_empty = r_empty;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_quo   = i_in_req.first_output_index;
                    n_rem   = '0;
                    n_step  = '0;
                    n_count = i_in_req.last_output_index - i_in_req.first_output_index;
                    n_empty = i_in_req.first_output_index > i_in_req.last_output_index;
                    n_state = n_empty ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV: begin
                n_quo  = {r_quo[crfs_pkg::IDX_W-2:0], div_ge};
                n_rem  = div_r[crfs_pkg::DIM_W-1:0];
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Divider and job payload
    always_ff @(posedge i_clk) begin
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_count <= n_count;
        r_empty <= n_empty;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_push      = (r_state == ST_PUSH) && !i_full;
    assign o_job.empty = r_empty;
    assign o_job.row   = r_quo;
    assign o_job.col   = r_rem;
    assign o_job.count = r_count;

    // Partial remainder stays below the divisor through the divide
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < i_cfg.output_width))
        else $error("divider remainder reached the divisor");

endmodule

@@ hdl/crfs_queue.sv @@
module crfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crfs_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output crfs_pkg::t_job  o_job
);

    localparam int PTR_W = (crfs_pkg::QDEPTH > 1) ? $clog2(crfs_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(crfs_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(crfs_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(crfs_pkg::QDEPTH);

    crfs_pkg::t_job    r_mem [crfs_pkg::QDEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];

    // No write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != CNT_FULL))
        else $error("job queue overflow");

endmodule

@@ hdl/crfs_back.sv @@
module crfs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crfs_pkg::t_cfg      i_cfg,
    input  logic                i_job_valid,
    input  crfs_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    output crfs_pkg::t_out_rsp  o_out_rsp,
    input  logic                i_out_ready
);

    localparam int IW   = crfs_pkg::IDX_W;
    localparam int DW   = crfs_pkg::DIM_W;
    localparam int PR_W = IW + crfs_pkg::STR_W;   // row position times stride
    localparam int PC_W = DW + crfs_pkg::STR_W;   // column position times stride
    localparam int RE_W = PR_W + 2;               // signed row end
    localparam int CE_W = PC_W + 2;               // signed column end
    localparam int LP_W = PR_W + DW;              // first-row product
    localparam int HP_W = RE_W + DW + 1;          // last-row product, signed
    localparam int LS_W = LP_W + 1;
    localparam int HS_W = HP_W + 1;

    // Control
    logic r_busy, r_walk;
    logic r_v1, r_v2, r_v3;
    logic r_l1, r_l2, r_l3;
    logic r_out_valid;

    // Walker
    logic [IW-1:0] r_row;
    logic [DW-1:0] r_col;
    logic [IW-1:0] r_left;

    // Pipeline payload
    logic [PR_W-1:0]        r_s1_row0;
    logic signed [RE_W-1:0] r_s1_rend;
    logic [PC_W-1:0]        r_s1_col0;
    logic signed [CE_W-1:0] r_s1_cend;
    logic [LP_W-1:0]        r_s2_lop;
    logic signed [HP_W-1:0] r_s2_hip;
    logic [PC_W-1:0]        r_s2_col0;
    logic signed [CE_W-1:0] r_s2_cend;
    logic [IW-1:0]          r_s3_lo;
    logic [IW-1:0]          r_s3_hi;
    logic [IW-1:0]          r_mn;
    logic [IW-1:0]          r_mx;
    crfs_pkg::t_out_rsp     r_out;

    logic                   pop;
    logic                   wrap;
    logic [PR_W-1:0]        prow;
    logic [PC_W-1:0]        pcol;
    logic [PR_W-1:0]        row0;
    logic [PC_W-1:0]        col0;
    logic signed [RE_W-1:0] row_sum, row_end;
    logic signed [CE_W-1:0] col_sum, col_end;
    logic signed [DW:0]     iw_s;
    logic [LP_W-1:0]        lo_prod;
    logic signed [HP_W-1:0] hi_prod;
    logic [LS_W-1:0]        lo_sum;
    logic signed [HS_W-1:0] hi_sum;
    logic [IW-1:0]          lo_clip, hi_clip;
    logic [IW-1:0]          mn_next, mx_next;

    // Take a job only when the result slot will be free
    assign pop   = i_job_valid && !r_busy && (!r_out_valid || i_out_ready);
    assign o_pop = pop;
    assign wrap  = (r_col == (i_cfg.output_width - 1'b1));

    // Stage 1: window placement on both axes (start and clipped end)
    always_comb begin
        prow    = PR_W'(r_row) * PR_W'(i_cfg.stride_v);
        row0    = (prow < PR_W'(i_cfg.pad_top)) ? '0 : prow - PR_W'(i_cfg.pad_top);
        row_sum = $signed(RE_W'(prow)) - $signed(RE_W'(i_cfg.pad_top))
                + $signed(RE_W'(i_cfg.kernel_height));
        row_end = ((row_sum > $signed(RE_W'(i_cfg.input_height)))
                   ? $signed(RE_W'(i_cfg.input_height)) : row_sum) - RE_W'(1);

        pcol    = PC_W'(r_col) * PC_W'(i_cfg.stride_col);
        col0    = (pcol < PC_W'(i_cfg.pad_left)) ? '0 : pcol - PC_W'(i_cfg.pad_left);
        col_sum = $signed(CE_W'(pcol)) - $signed(CE_W'(i_cfg.pad_left))
                + $signed(CE_W'(i_cfg.kernel_width));
        col_end = ((col_sum > $signed(CE_W'(i_cfg.input_width)))
                   ? $signed(CE_W'(i_cfg.input_width)) : col_sum) - CE_W'(1);
    end

    // Stage 2: first and last window rows times the input width
    always_comb begin
        iw_s    = $signed({1'b0, i_cfg.input_width});
        lo_prod = LP_W'(r_s1_row0) * LP_W'(i_cfg.input_width);
        hi_prod = r_s1_rend * iw_s;
    end

    // Stage 3: add the columns and clip to the index range
    always_comb begin
        lo_sum  = LS_W'(r_s2_lop) + LS_W'(r_s2_col0);
        hi_sum  = r_s2_hip + r_s2_cend;
        lo_clip = (lo_sum > LS_W'(crfs_pkg::IDX_MAX)) ? crfs_pkg::IDX_MAX : lo_sum[IW-1:0];
        if (hi_sum < 0) begin
            hi_clip = '0;
        end else if (hi_sum > $signed(HS_W'(crfs_pkg::IDX_MAX))) begin
            hi_clip = crfs_pkg::IDX_MAX;
        end else begin
            hi_clip = hi_sum[IW-1:0];
        end
    end

    // Stage 4: running min and max
    assign mn_next = (r_s3_lo < r_mn) ? r_s3_lo : r_mn;
    assign mx_next = (r_s3_hi > r_mx) ? r_s3_hi : r_mx;

    // Control: job, walk, pipeline valids, result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_walk      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= r_walk;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                if (i_job.empty) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_walk <= 1'b1;
                end
            end
            if (r_walk && (r_left == '0)) begin
                r_walk <= 1'b0;
            end
            if (r_v3 && r_l3) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // walker: row-major step through the range
        if (pop) begin
            r_row  <= i_job.row;
            r_col  <= i_job.col;
            r_left <= i_job.count;
        end else if (r_walk) begin
            r_left <= r_left - 1'b1;
            if (wrap) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end

        r_l1      <= (r_left == '0);
        r_s1_row0 <= row0;
        r_s1_rend <= row_end;
        r_s1_col0 <= col0;
        r_s1_cend <= col_end;

        r_l2      <= r_l1;
        r_s2_lop  <= lo_prod;
        r_s2_hip  <= hi_prod;
        r_s2_col0 <= r_s1_col0;
        r_s2_cend <= r_s1_cend;

        r_l3      <= r_l2;
        r_s3_lo   <= lo_clip;
        r_s3_hi   <= hi_clip;

        // accumulators
        if (pop) begin
            r_mn <= crfs_pkg::EMPTY_MIN;
            r_mx <= '0;
        end else if (r_v3) begin
            r_mn <= mn_next;
            r_mx <= mx_next;
        end

        // result slot
        if (pop && i_job.empty) begin
            r_out.min_input_index <= crfs_pkg::EMPTY_MIN;
            r_out.max_input_index <= '0;
        end else if (r_v3 && r_l3) begin
            r_out.min_input_index <= mn_next;
            r_out.max_input_index <= mx_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // A job in flight never overlaps a result waiting in the slot
    a_busy_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("result slot filled while a job is running");

    // Walker only runs inside a job
    a_walk_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk |-> r_busy)
        else $error("walker active without a job");

    // Positions reaching the accumulators belong to the live job
    a_acc_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_busy)
        else $error("pipeline output without a job");

endmodule

@@ hdl/conv_receptive_field_span.sv @@
// Input-window span of a range of convolution outputs.
//
// Input channel (i_in_valid / o_in_ready / i_in_req): one request carries an
// inclusive range of flat output indices. Output channel (o_out_valid /
// i_out_ready / o_out_rsp): exactly one result per request, in order, with
// the smallest first and largest last flat input index of the windows. An
// empty range (first > last) returns 1000000 and 0. Configuration is written
// over the APB port while no request is in flight (user rule, not checked).
//
// The front splits the first index into row and column with a 20-step
// divider, queues the job, and takes a new request only once that job is
// in the queue. The back walks the range at one output position per cycle
// through a 4-stage placement/multiply/add/compare pipeline; it takes a new
// job only when no job is running and its result slot is free or being read.
// The front keeps accepting while a result waits; when the receiver stalls
// the back holds its result and stops taking jobs, the two-entry queue
// fills, and then the input channel stalls. Reset empties the queue and the
// pipeline and loads the register defaults.
module conv_receptive_field_span #(
    parameter int MAX_DIM    = crfs_pkg::MAX_DIM_DEF,
    parameter int MAX_KERNEL = crfs_pkg::MAX_KERNEL_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  crfs_pkg::t_in_req                  i_in_req,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output crfs_pkg::t_out_rsp                 o_out_rsp,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crfs_pkg::ADDR_W-1:0]        paddr,
    input  logic [crfs_pkg::DATA_W-1:0]        pwdata,
    output logic [crfs_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int DW = crfs_pkg::DIM_W;
    localparam int KW = crfs_pkg::KER_W;
    localparam int SW = crfs_pkg::STR_W;
    localparam int PW = crfs_pkg::PAD_W;

    logic [DW-1:0]     r_input_height;
    logic [DW-1:0]     r_input_width;
    logic [KW-1:0]     r_kernel_height;
    logic [KW-1:0]     r_kernel_width;
    logic [2*SW-1:0]   r_strides;
    logic [PW-1:0]     r_pad_top;
    logic [PW-1:0]     r_pad_left;
    logic [DW-1:0]     r_output_width;

    logic                        cfg_we;
    logic [crfs_pkg::RIDX_W-1:0] reg_idx;
    crfs_pkg::t_cfg              cfg;

    logic            push, full, pop, job_valid;
    crfs_pkg::t_job  push_job, pop_job;

    // Saturate a dimension to [1, MAX_DIM]
    function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DW'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Saturate a kernel size to [1, MAX_KERNEL]
    function automatic logic [KW-1:0] sat_ker(input logic [KW-1:0] v);
        logic [KW-1:0] r;
        if (v == '0) begin
            r = KW'(1);
        end else if (32'(v) > MAX_KERNEL) begin
            r = KW'(MAX_KERNEL);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // APB write decode
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[crfs_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_height  <= DW'(1);
            r_input_width   <= DW'(1);
            r_kernel_height <= KW'(1);
            r_kernel_width  <= KW'(1);
            r_strides       <= 8'h11;
            r_pad_top       <= '0;
            r_pad_left      <= '0;
            r_output_width  <= DW'(1);
        end else if (cfg_we) begin
            unique case (reg_idx)
                crfs_pkg::REG_INPUT_HEIGHT:  r_input_height  <= pwdata[DW-1:0];
                crfs_pkg::REG_INPUT_WIDTH:   r_input_width   <= pwdata[DW-1:0];
                crfs_pkg::REG_KERNEL_HEIGHT: r_kernel_height <= pwdata[KW-1:0];
                crfs_pkg::REG_KERNEL_WIDTH:  r_kernel_width  <= pwdata[KW-1:0];
                crfs_pkg::REG_STRIDES:       r_strides       <= pwdata[2*SW-1:0];
                crfs_pkg::REG_PAD_TOP:       r_pad_top       <= pwdata[PW-1:0];
                crfs_pkg::REG_PAD_LEFT:      r_pad_left      <= pwdata[PW-1:0];
                crfs_pkg::REG_OUTPUT_WIDTH:  r_output_width  <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // APB read
    always_comb begin
        unique case (reg_idx)
            crfs_pkg::REG_INPUT_HEIGHT:  prdata = crfs_pkg::DATA_W'(r_input_height);
            crfs_pkg::REG_INPUT_WIDTH:   prdata = crfs_pkg::DATA_W'(r_input_width);
            crfs_pkg::REG_KERNEL_HEIGHT: prdata = crfs_pkg::DATA_W'(r_kernel_height);
            crfs_pkg::REG_KERNEL_WIDTH:  prdata = crfs_pkg::DATA_W'(r_kernel_width);
            crfs_pkg::REG_STRIDES:       prdata = crfs_pkg::DATA_W'(r_strides);
            crfs_pkg::REG_PAD_TOP:       prdata = crfs_pkg::DATA_W'(r_pad_top);
            crfs_pkg::REG_PAD_LEFT:      prdata = crfs_pkg::DATA_W'(r_pad_left);
            crfs_pkg::REG_OUTPUT_WIDTH:  prdata = crfs_pkg::DATA_W'(r_output_width);
            default:                     prdata = '0;
        endcase
    end

    // Effective configuration: saturated sizes, zero stride taken as one
    always_comb begin
        cfg.input_height  = sat_dim(r_input_height);
        cfg.input_width   = sat_dim(r_input_width);
        cfg.kernel_height = sat_ker(r_kernel_height);
        cfg.kernel_width  = sat_ker(r_kernel_width);
        cfg.stride_v      = (r_strides[2*SW-1:SW] == '0) ? SW'(1) : r_strides[2*SW-1:SW];
        cfg.stride_col    = (r_strides[SW-1:0] == '0) ? SW'(1) : r_strides[SW-1:0];
        cfg.pad_top       = r_pad_top;
        cfg.pad_left      = r_pad_left;
        cfg.output_width  = sat_dim(r_output_width);
    end

    crfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_req   (i_in_req),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    crfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (pop_job)
    );

    crfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_ready (i_out_ready)
    );

endmodule
